FILE: design/lvn_pkg.sv
// Shared constants and the 32-bit saturation helper for the look-at view matrix pipeline.
package lvn_pkg;

  localparam int DATA_W     = 32;
  localparam int NORM_TOP   = 29;
  localparam int MANT_W     = 30;
  localparam int SUM_W      = 62;
  localparam int ROOT_W     = 31;
  localparam int ROOT_STEPS = 31;
  localparam int RAD_W      = 64;

  function automatic logic [DATA_W-1:0] sat32(input logic signed [63:0] v);
    logic [DATA_W-1:0] res;
    if (v > 64'sh0000_0000_7FFF_FFFF) begin
      res = 32'h7FFF_FFFF;
    end else if (v < -64'sh0000_0000_8000_0000) begin
      res = 32'h8000_0000;
    end else begin
      res = v[DATA_W-1:0];
    end
    return res;
  endfunction

endpackage

FILE: design/look_at_view_matrix_core.sv
// Look-at view matrix generator: top level with cross products, dot products and output.
// Each request carries eye, target and up in signed fixed point and yields one result, the
// top three rows of the view matrix (r, -r.eye), (u, -u.eye), (-f, f.eye), saturated to
// 32 bits; a zero-length forward or right vector gives an all-zero result. A new request is
// taken every cycle while the output is free or being taken. Each request passes through the
// two normalisers, each a chain of 31 square-root cells and FRAC_BITS+1 divider cells; the
// whole pipeline holds while the output stalls.
module look_at_view_matrix_core #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z (32 bits each)
  input  logic [287:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // row0_col0..row0_col3, row1_col0..row1_col3, row2_col0..row2_col3 (32 bits each)
  output logic [383:0] out_tdata
);

  localparam int DW   = lvn_pkg::DATA_W;
  localparam int FW   = FRAC_BITS + 2;
  localparam int UW   = FW + 1;
  localparam int PFW  = FW + DW;
  localparam int CW   = FRAC_BITS + 34;
  localparam int RW   = 2 * FW;
  localparam int TW   = UW + DW;
  localparam int SW1  = 6 * DW;
  localparam int SW2  = 1 + 3 * DW + 3 * FW;

  function automatic logic signed [63:0] drop_frac(input logic signed [63:0] x);
    logic [63:0] mag;
    logic [63:0] q;
    mag = x[63] ? (64'd0 - 64'(x)) : 64'(x);
    q   = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
    return x[63] ? $signed(64'd0 - q) : $signed(q);
  endfunction

  logic en;
  logic out_valid_r;
  logic [383:0] out_data_r;

  assign en        = !out_valid_r || out_tready;
  assign in_tready = en;

  // Forward difference
  logic [2:0][DW:0]   d0_nxt, d0_r;
  logic [2:0][DW-1:0] eye0_r, up0_r;
  logic               v0_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d0_nxt[i] = {in_tdata[(3+i)*DW+DW-1], in_tdata[(3+i)*DW +: DW]}
                - {in_tdata[i*DW+DW-1], in_tdata[i*DW +: DW]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
    end else if (en) begin
      v0_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d0_r <= d0_nxt;
      for (int i = 0; i < 3; i++) begin
        eye0_r[i] <= in_tdata[i*DW +: DW];
        up0_r[i]  <= in_tdata[(6+i)*DW +: DW];
      end
    end
  end

  // Forward unit vector
  logic                n1_valid, n1_zero;
  logic [3*FW-1:0]     n1_unit;
  logic [SW1-1:0]      n1_side;

  lvn_norm #(
    .FRAC_BITS (FRAC_BITS),
    .IW        (DW + 1),
    .SW        (SW1)
  ) u_norm_f (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v0_r),
    .in_vec    (d0_r),
    .in_side   ({eye0_r, up0_r}),
    .out_valid (n1_valid),
    .out_unit  (n1_unit),
    .out_zero  (n1_zero),
    .out_side  (n1_side)
  );

  logic signed [FW-1:0] f1 [3];
  logic signed [DW-1:0] up1 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      f1[i]  = $signed(n1_unit[i*FW +: FW]);
      up1[i] = $signed(n1_side[i*DW +: DW]);
    end
  end

  // f x up, products then differences
  logic signed [PFW-1:0] pa2_r [3];
  logic signed [PFW-1:0] pb2_r [3];
  logic [3*FW-1:0]       f2_r;
  logic [3*DW-1:0]       eye2_r;
  logic                  z2_r, v2_r;

  logic [3*CW-1:0]       c3_r;
  logic [3*FW-1:0]       f3_r;
  logic [3*DW-1:0]       eye3_r;
  logic                  z3_r, v3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v2_r <= n1_valid;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa2_r[i] <= f1[(i+1)%3] * up1[(i+2)%3];
        pb2_r[i] <= f1[(i+2)%3] * up1[(i+1)%3];
        c3_r[i*CW +: CW] <= CW'(pa2_r[i]) - CW'(pb2_r[i]);
      end
      f2_r   <= n1_unit;
      eye2_r <= n1_side[SW1-1 -: 3*DW];
      z2_r   <= n1_zero;
      f3_r   <= f2_r;
      eye3_r <= eye2_r;
      z3_r   <= z2_r;
    end
  end

  // Right unit vector
  logic                n2_valid, n2_zero;
  logic [3*FW-1:0]     n2_unit;
  logic [SW2-1:0]      n2_side;

  lvn_norm #(
    .FRAC_BITS (FRAC_BITS),
    .IW        (CW),
    .SW        (SW2)
  ) u_norm_r (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .in_vec    (c3_r),
    .in_side   ({z3_r, eye3_r, f3_r}),
    .out_valid (n2_valid),
    .out_unit  (n2_unit),
    .out_zero  (n2_zero),
    .out_side  (n2_side)
  );

  logic signed [FW-1:0] r4 [3];
  logic signed [FW-1:0] f4 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      r4[i] = $signed(n2_unit[i*FW +: FW]);
      f4[i] = $signed(n2_side[i*FW +: FW]);
    end
  end

  // r x f, products, differences, rounding; then the dot products with eye
  logic signed [RW-1:0]   pa4_r [3];
  logic signed [RW-1:0]   pb4_r [3];
  logic signed [RW:0]     u5_r [3];
  logic signed [UW-1:0]   u6_r [3];
  logic signed [FW-1:0]   r4_r [3], r5_r [3], r6_r [3], r7_r [3], r8_r [3];
  logic signed [FW-1:0]   f4_r [3], f5_r [3], f6_r [3], f7_r [3], f8_r [3];
  logic signed [UW-1:0]   u7_r [3], u8_r [3];
  logic signed [DW-1:0]   eye4_r [3], eye5_r [3], eye6_r [3];
  logic signed [TW-1:0]   tr7_r [3], tu7_r [3], tf7_r [3];
  logic signed [TW+1:0]   sr8_r, su8_r, sf8_r;
  logic                   z4_r, z5_r, z6_r, z7_r, z8_r;
  logic                   v4_r, v5_r, v6_r, v7_r, v8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (en) begin
      v4_r <= n2_valid;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pa4_r[i]  <= r4[(i+1)%3] * f4[(i+2)%3];
        pb4_r[i]  <= r4[(i+2)%3] * f4[(i+1)%3];
        r4_r[i]   <= r4[i];
        f4_r[i]   <= f4[i];
        eye4_r[i] <= $signed(n2_side[3*FW + i*DW +: DW]);

        u5_r[i]   <= (RW+1)'(pa4_r[i]) - (RW+1)'(pb4_r[i]);
        r5_r[i]   <= r4_r[i];
        f5_r[i]   <= f4_r[i];
        eye5_r[i] <= eye4_r[i];

        u6_r[i]   <= UW'(drop_frac(64'(u5_r[i])));
        r6_r[i]   <= r5_r[i];
        f6_r[i]   <= f5_r[i];
        eye6_r[i] <= eye5_r[i];

        tr7_r[i]  <= TW'(r6_r[i]) * TW'(eye6_r[i]);
        tu7_r[i]  <= TW'(u6_r[i]) * TW'(eye6_r[i]);
        tf7_r[i]  <= TW'(f6_r[i]) * TW'(eye6_r[i]);
        r7_r[i]   <= r6_r[i];
        u7_r[i]   <= u6_r[i];
        f7_r[i]   <= f6_r[i];

        r8_r[i]   <= r7_r[i];
        u8_r[i]   <= u7_r[i];
        f8_r[i]   <= f7_r[i];
      end
      sr8_r <= (TW+2)'(tr7_r[0]) + (TW+2)'(tr7_r[1]) + (TW+2)'(tr7_r[2]);
      su8_r <= (TW+2)'(tu7_r[0]) + (TW+2)'(tu7_r[1]) + (TW+2)'(tu7_r[2]);
      sf8_r <= (TW+2)'(tf7_r[0]) + (TW+2)'(tf7_r[1]) + (TW+2)'(tf7_r[2]);
      z4_r  <= n2_zero || n2_side[SW2-1];
      z5_r  <= z4_r;
      z6_r  <= z5_r;
      z7_r  <= z6_r;
      z8_r  <= z7_r;
    end
  end

  // Output register
  logic [383:0] out_data_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      out_data_nxt[i*DW +: DW]       = lvn_pkg::sat32(64'(r8_r[i]));
      out_data_nxt[(4+i)*DW +: DW]   = lvn_pkg::sat32(64'(u8_r[i]));
      out_data_nxt[(8+i)*DW +: DW]   = lvn_pkg::sat32(64'sd0 - 64'(f8_r[i]));
    end
    out_data_nxt[3*DW +: DW]  = lvn_pkg::sat32(64'sd0 - drop_frac(64'(sr8_r)));
    out_data_nxt[7*DW +: DW]  = lvn_pkg::sat32(64'sd0 - drop_frac(64'(su8_r)));
    out_data_nxt[11*DW +: DW] = lvn_pkg::sat32(drop_frac(64'(sf8_r)));
    if (z8_r) begin
      out_data_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

`ifndef SYNTHESIS
  a_in_enters : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> v0_r)
    else $error("accepted request did not enter the first stage");

  a_stall_blocks : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("input taken while the output is stalled");

  a_last_stage : assert property (@(posedge clk) disable iff (!rst_n)
    en && v8_r |=> out_valid_r)
    else $error("result lost between the last stage and the output");
`endif

endmodule

FILE: design/lvn_sqrt_cell.sv
// One bit step of the pipelined integer square root.
module lvn_sqrt_cell #(
  parameter int STEP = 0,
  parameter int SW   = 1
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [lvn_pkg::RAD_W-1:0]  in_n,
  input  logic [lvn_pkg::RAD_W-1:0]  in_res,
  input  logic [SW-1:0]              in_side,
  output logic                       out_valid,
  output logic [lvn_pkg::RAD_W-1:0]  out_n,
  output logic [lvn_pkg::RAD_W-1:0]  out_res,
  output logic [SW-1:0]              out_side
);

  localparam logic [lvn_pkg::RAD_W-1:0] BIT_VAL = lvn_pkg::RAD_W'(1) << (2 * STEP);

  logic [lvn_pkg::RAD_W-1:0] trial;
  logic [lvn_pkg::RAD_W-1:0] n_nxt, res_nxt;
  logic [lvn_pkg::RAD_W-1:0] n_r, res_r;
  logic [SW-1:0]             side_r;
  logic                      valid_r;

  always_comb begin
    trial = in_res + BIT_VAL;
    if (in_n >= trial) begin
      n_nxt   = in_n - trial;
      res_nxt = (in_res >> 1) + BIT_VAL;
    end else begin
      n_nxt   = in_n;
      res_nxt = in_res >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n_r    <= n_nxt;
      res_r  <= res_nxt;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_n     = n_r;
  assign out_res   = res_r;
  assign out_side  = side_r;

endmodule

FILE: design/lvn_div_cell.sv
// One quotient bit step of the three-lane pipelined divider.
module lvn_div_cell #(
  parameter int STEP = 0,
  parameter int NW   = 48,
  parameter int QW   = 17,
  parameter int SW   = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [2:0][NW-1:0]          in_rem,
  input  logic [2:0][QW-1:0]          in_quo,
  input  logic [lvn_pkg::ROOT_W-1:0]  in_den,
  input  logic [SW-1:0]               in_side,
  output logic                        out_valid,
  output logic [2:0][NW-1:0]          out_rem,
  output logic [2:0][QW-1:0]          out_quo,
  output logic [lvn_pkg::ROOT_W-1:0]  out_den,
  output logic [SW-1:0]               out_side
);

  logic [NW-1:0]             shifted;
  logic [2:0][NW-1:0]        rem_nxt, rem_r;
  logic [2:0][QW-1:0]        quo_nxt, quo_r;
  logic [lvn_pkg::ROOT_W-1:0] den_r;
  logic [SW-1:0]             side_r;
  logic                      valid_r;

  always_comb begin
    shifted = NW'(in_den) << STEP;
    for (int i = 0; i < 3; i++) begin
      if (in_rem[i] >= shifted) begin
        rem_nxt[i] = in_rem[i] - shifted;
        quo_nxt[i] = in_quo[i] | (QW'(1) << STEP);
      end else begin
        rem_nxt[i] = in_rem[i];
        quo_nxt[i] = in_quo[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quo_r  <= quo_nxt;
      den_r  <= in_den;
      side_r <= in_side;
    end
  end

  assign out_valid = valid_r;
  assign out_rem   = rem_r;
  assign out_quo   = quo_r;
  assign out_den   = den_r;
  assign out_side  = side_r;

endmodule

FILE: design/lvn_norm.sv
// Pipelined normalisation of a signed three-vector to unit length.
module lvn_norm #(
  parameter int FRAC_BITS = 16,
  parameter int IW        = 33,
  parameter int SW        = 1
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic                           in_valid,
  input  logic [3*IW-1:0]                in_vec,
  input  logic [SW-1:0]                  in_side,
  output logic                           out_valid,
  output logic [3*(FRAC_BITS+2)-1:0]     out_unit,
  output logic                           out_zero,
  output logic [SW-1:0]                  out_side
);

  localparam int FW    = FRAC_BITS + 2;
  localparam int QW    = FRAC_BITS + 1;
  localparam int NW    = lvn_pkg::ROOT_W + FRAC_BITS + 1;
  localparam int PW    = $clog2(IW);
  localparam int MW    = lvn_pkg::MANT_W;
  localparam int SQ_SW = 3 * MW + 3 + 1 + SW;
  localparam int DV_SW = 3 + 1 + SW;

  // Magnitudes and signs
  logic [2:0][IW-1:0] mag_a_nxt, mag_a_r;
  logic [2:0]         sgn_a_r;
  logic [SW-1:0]      side_a_r;
  logic               v_a_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag_a_nxt[i] = in_vec[i*IW+IW-1] ? (~in_vec[i*IW +: IW] + IW'(1)) : in_vec[i*IW +: IW];
    end
  end

  // Largest magnitude
  logic [2:0][IW-1:0] mag_b_r;
  logic [IW-1:0]      mx_b_nxt, mx_b_r;
  logic [2:0]         sgn_b_r;
  logic [SW-1:0]      side_b_r;
  logic               v_b_r;

  always_comb begin
    mx_b_nxt = mag_a_r[0];
    if (mag_a_r[1] > mx_b_nxt) begin
      mx_b_nxt = mag_a_r[1];
    end
    if (mag_a_r[2] > mx_b_nxt) begin
      mx_b_nxt = mag_a_r[2];
    end
  end

  // Leading one position
  logic [2:0][IW-1:0] mag_c_r;
  logic [PW-1:0]      pos_c_nxt, pos_c_r;
  logic               zero_c_r;
  logic [2:0]         sgn_c_r;
  logic [SW-1:0]      side_c_r;
  logic               v_c_r;

  always_comb begin
    pos_c_nxt = '0;
    for (int j = 0; j < IW; j++) begin
      if (mx_b_r[j]) begin
        pos_c_nxt = PW'(j);
      end
    end
  end

  // Common shift bringing the largest magnitude to the top of the mantissa
  logic [2:0][MW-1:0] m_d_nxt, m_d_r;
  logic [IW+MW-1:0]   wide;
  logic               zero_d_r;
  logic [2:0]         sgn_d_r;
  logic [SW-1:0]      side_d_r;
  logic               v_d_r;

  always_comb begin
    wide = '0;
    for (int i = 0; i < 3; i++) begin
      wide = {{MW{1'b0}}, mag_c_r[i]};
      if (pos_c_r >= PW'(lvn_pkg::NORM_TOP)) begin
        wide = wide >> (pos_c_r - PW'(lvn_pkg::NORM_TOP));
      end else begin
        wide = wide << (PW'(lvn_pkg::NORM_TOP) - pos_c_r);
      end
      m_d_nxt[i] = wide[MW-1:0];
    end
  end

  // Squares
  logic [2:0][2*MW-1:0] sq_e_r;
  logic [2:0][MW-1:0]   m_e_r;
  logic                 zero_e_r;
  logic [2:0]           sgn_e_r;
  logic [SW-1:0]        side_e_r;
  logic                 v_e_r;

  // Sum of squares
  logic [lvn_pkg::SUM_W-1:0] sum_f_r;
  logic [2:0][MW-1:0]        m_f_r;
  logic                      zero_f_r;
  logic [2:0]                sgn_f_r;
  logic [SW-1:0]             side_f_r;
  logic                      v_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
      v_b_r <= 1'b0;
      v_c_r <= 1'b0;
      v_d_r <= 1'b0;
      v_e_r <= 1'b0;
      v_f_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_valid;
      v_b_r <= v_a_r;
      v_c_r <= v_b_r;
      v_d_r <= v_c_r;
      v_e_r <= v_d_r;
      v_f_r <= v_e_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r  <= mag_a_nxt;
      for (int i = 0; i < 3; i++) begin
        sgn_a_r[i] <= in_vec[i*IW+IW-1];
      end
      side_a_r <= in_side;

      mag_b_r  <= mag_a_r;
      mx_b_r   <= mx_b_nxt;
      sgn_b_r  <= sgn_a_r;
      side_b_r <= side_a_r;

      mag_c_r  <= mag_b_r;
      pos_c_r  <= pos_c_nxt;
      zero_c_r <= (mx_b_r == '0);
      sgn_c_r  <= sgn_b_r;
      side_c_r <= side_b_r;

      m_d_r    <= m_d_nxt;
      zero_d_r <= zero_c_r;
      sgn_d_r  <= sgn_c_r;
      side_d_r <= side_c_r;

      for (int i = 0; i < 3; i++) begin
        sq_e_r[i] <= (2*MW)'(m_d_r[i]) * (2*MW)'(m_d_r[i]);
      end
      m_e_r    <= m_d_r;
      zero_e_r <= zero_d_r;
      sgn_e_r  <= sgn_d_r;
      side_e_r <= side_d_r;

      sum_f_r  <= lvn_pkg::SUM_W'(sq_e_r[0]) + lvn_pkg::SUM_W'(sq_e_r[1])
                + lvn_pkg::SUM_W'(sq_e_r[2]);
      m_f_r    <= m_e_r;
      zero_f_r <= zero_e_r;
      sgn_f_r  <= sgn_e_r;
      side_f_r <= side_e_r;
    end
  end

  // Square root, one result bit per cell
  logic [lvn_pkg::ROOT_STEPS:0]                   sq_v;
  logic [lvn_pkg::ROOT_STEPS:0][lvn_pkg::RAD_W-1:0] sq_n;
  logic [lvn_pkg::ROOT_STEPS:0][lvn_pkg::RAD_W-1:0] sq_res;
  logic [lvn_pkg::ROOT_STEPS:0][SQ_SW-1:0]        sq_side;

  assign sq_v[0]    = v_f_r;
  assign sq_n[0]    = lvn_pkg::RAD_W'(sum_f_r);
  assign sq_res[0]  = '0;
  assign sq_side[0] = {m_f_r, sgn_f_r, zero_f_r, side_f_r};

  for (genvar g = 0; g < lvn_pkg::ROOT_STEPS; g++) begin : g_sqrt
    lvn_sqrt_cell #(
      .STEP (lvn_pkg::ROOT_STEPS - 1 - g),
      .SW   (SQ_SW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (sq_v[g]),
      .in_n      (sq_n[g]),
      .in_res    (sq_res[g]),
      .in_side   (sq_side[g]),
      .out_valid (sq_v[g+1]),
      .out_n     (sq_n[g+1]),
      .out_res   (sq_res[g+1]),
      .out_side  (sq_side[g+1])
    );
  end

  // Rounded dividends
  logic [lvn_pkg::ROOT_W-1:0] len_g;
  logic [2:0][MW-1:0]         m_g;
  logic [DV_SW-1:0]           dvside_g;
  logic [2:0][NW-1:0]         num_g_nxt, num_g_r;
  logic [lvn_pkg::ROOT_W-1:0] len_g_r;
  logic [DV_SW-1:0]           dvside_g_r;
  logic                       v_g_r;

  assign len_g    = sq_res[lvn_pkg::ROOT_STEPS][lvn_pkg::ROOT_W-1:0];
  assign m_g      = sq_side[lvn_pkg::ROOT_STEPS][SQ_SW-1 -: 3*MW];
  assign dvside_g = sq_side[lvn_pkg::ROOT_STEPS][DV_SW-1:0];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      num_g_nxt[i] = (NW'(m_g[i]) << FRAC_BITS) + NW'(len_g >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_g_r <= 1'b0;
    end else if (en) begin
      v_g_r <= sq_v[lvn_pkg::ROOT_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num_g_r    <= num_g_nxt;
      len_g_r    <= len_g;
      dvside_g_r <= dvside_g;
    end
  end

  // Division, one quotient bit per cell
  logic [QW:0]                        dv_v;
  logic [QW:0][2:0][NW-1:0]           dv_rem;
  logic [QW:0][2:0][QW-1:0]           dv_quo;
  logic [QW:0][lvn_pkg::ROOT_W-1:0]   dv_den;
  logic [QW:0][DV_SW-1:0]             dv_side;

  assign dv_v[0]    = v_g_r;
  assign dv_rem[0]  = num_g_r;
  assign dv_quo[0]  = '0;
  assign dv_den[0]  = len_g_r;
  assign dv_side[0] = dvside_g_r;

  for (genvar g = 0; g < QW; g++) begin : g_div
    lvn_div_cell #(
      .STEP (QW - 1 - g),
      .NW   (NW),
      .QW   (QW),
      .SW   (DV_SW)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .en        (en),
      .in_valid  (dv_v[g]),
      .in_rem    (dv_rem[g]),
      .in_quo    (dv_quo[g]),
      .in_den    (dv_den[g]),
      .in_side   (dv_side[g]),
      .out_valid (dv_v[g+1]),
      .out_rem   (dv_rem[g+1]),
      .out_quo   (dv_quo[g+1]),
      .out_den   (dv_den[g+1]),
      .out_side  (dv_side[g+1])
    );
  end

  // Sign restore
  logic [2:0]            sgn_h;
  logic [3*FW-1:0]       unit_h_nxt, unit_h_r;
  logic                  zero_h_r;
  logic [SW-1:0]         side_h_r;
  logic                  v_h_r;

  assign sgn_h = dv_side[QW][DV_SW-1 -: 3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unit_h_nxt[i*FW +: FW] = sgn_h[i] ? (FW'(0) - FW'(dv_quo[QW][i])) : FW'(dv_quo[QW][i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_h_r <= 1'b0;
    end else if (en) begin
      v_h_r <= dv_v[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      unit_h_r <= unit_h_nxt;
      zero_h_r <= dv_side[QW][SW];
      side_h_r <= dv_side[QW][SW-1:0];
    end
  end

  assign out_valid = v_h_r;
  assign out_unit  = unit_h_r;
  assign out_zero  = zero_h_r;
  assign out_side  = side_h_r;

endmodule
